// ----- hdl/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int IDX_W = $clog2(POOL_SLOTS);
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);

  typedef enum logic [2:0] {
    ACT_ALLOC      = 3'd0,
    ACT_REL_ID     = 3'd1,
    ACT_REL_LOC    = 3'd2,
    ACT_COUNT      = 3'd3,
    ACT_LOOKUP_ID  = 3'd4,
    ACT_LOOKUP_NTH = 3'd5,
    ACT_CLEAR      = 3'd6,
    ACT_UNUSED     = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [7:0]  kind;
    logic [31:0] qty;
    logic [15:0] loc_index;
    logic [15:0] loc_gen;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_LF_RD,
    S_LF_CMP,
    S_LR_RD,
    S_LR_SL,
    S_LR_CMP,
    S_TAIL_RD,
    S_TAIL_WR
  } state_t;

endpackage

// ----- hdl/spa_req_if.sv -----
// ----------------------------------------------------------------------------
// spa_req_if
// Request channel of the slot pool allocator.
// ----------------------------------------------------------------------------
interface spa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] cargo_id;
  logic [7:0]  res_type;
  logic [31:0] amount;
  logic [15:0] loc_index;
  logic [15:0] loc_generation;
  logic [5:0]  position;

  modport source (
    output valid, action, cargo_id, res_type, amount, loc_index, loc_generation,
           position,
    input  ready
  );
  modport sink (
    input  valid, action, cargo_id, res_type, amount, loc_index, loc_generation,
           position,
    output ready
  );
endinterface

// ----- hdl/spa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spa_rsp_if
// Result channel of the slot pool allocator.
// ----------------------------------------------------------------------------
interface spa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_id;
  logic [5:0]  out_slot;
  logic [7:0]  out_type;
  logic [31:0] out_amount;
  logic [15:0] out_loc_index;
  logic [15:0] out_loc_generation;
  logic [6:0]  out_count;
  logic        last;

  modport source (
    output valid, status, out_id, out_slot, out_type, out_amount, out_loc_index,
           out_loc_generation, out_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_id, out_slot, out_type, out_amount, out_loc_index,
           out_loc_generation, out_count, last,
    output ready
  );
endinterface

// ----- hdl/spa_ram.sv -----
// ----------------------------------------------------------------------------
// spa_ram
// Simple dual-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/slot_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// slot_pool_allocator
// Fixed pool of slots with a dense list of the active slots.
// ----------------------------------------------------------------------------
// Every word other than clear and the unused action code first passes through
// a scan of all pool slots, one slot record read per cycle from the slot RAM.
// Clear and the unused action code go straight to the decision. Release by id
// adds a walk of the active list RAM up to the released entry, then a
// swap-and-pop of the list tail. Release by location walks the active list,
// reading each entry and then its slot record, with a swap-and-pop for each
// freed entry, giving one result word per freed entry. A new word is taken
// only when the block is idle, and a result word waiting in the output register
// holds the block.
module slot_pool_allocator (
  input logic       clk,
  input logic       rst,
  spa_req_if.sink   req,
  spa_rsp_if.source rsp
);

  localparam int IW = spa_pkg::IDX_W;
  localparam int CW = spa_pkg::CNT_W;
  localparam int NS = spa_pkg::POOL_SLOTS;

  spa_pkg::state_t state, state_next;

  logic [2:0]  act_q;
  logic [31:0] id_q;
  logic [7:0]  type_q;
  logic [31:0] amount_q;
  logic [15:0] li_q;
  logic [15:0] lg_q;
  logic [5:0]  pos_q;

  logic [NS-1:0] live;
  logic [CW-1:0] act_cnt;
  logic [31:0]   next_ident;
  logic [31:0]   ident_inc;

  logic [IW-1:0] scan_i;
  logic          iss_done;
  logic          cmp_v;
  logic [IW-1:0] cmp_i;
  logic [CW-1:0] scan_cnt;
  logic          found;
  logic [IW-1:0] hit_slot;
  spa_pkg::rec_t hit_rec;
  logic          hit;
  logic          sel;

  logic [CW-1:0] j;
  logic [CW-1:0] emitted;
  logic [CW-1:0] final_cnt;
  logic [IW-1:0] cur_s;

  logic          slot_we;
  logic [IW-1:0] slot_raddr;
  spa_pkg::rec_t slot_wdata;
  spa_pkg::rec_t slot_rdata;
  logic          list_we;
  logic [IW-1:0] list_waddr;
  logic [IW-1:0] list_wdata;
  logic [IW-1:0] list_raddr;
  logic [IW-1:0] list_rdata;

  logic          out_free;
  logic          load;
  spa_pkg::status_t res_status;
  logic          res_has_rec;
  spa_pkg::rec_t res_rec;
  logic [IW-1:0] res_slot;
  logic [CW-1:0] res_count;
  logic          res_last;

  logic          o_valid;
  logic [1:0]    o_status;
  spa_pkg::rec_t o_rec;
  logic [IW-1:0] o_slot;
  logic [CW-1:0] o_count;
  logic          o_last;

  spa_ram #(.WIDTH($bits(spa_pkg::rec_t)), .DEPTH(NS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (hit_slot),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  spa_ram #(.WIDTH(IW), .DEPTH(NS)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  assign out_free  = !o_valid || rsp.ready;
  assign ident_inc = (next_ident + 32'd1 == 32'd0) ? 32'd1 : next_ident + 32'd1;
  assign slot_wdata = '{ident: next_ident, kind: type_q, qty: amount_q,
                        loc_index: li_q, loc_gen: lg_q};

  always_comb begin
    hit = 1'b0;
    case (act_q)
      spa_pkg::ACT_ALLOC: begin
        hit = !live[cmp_i];
      end
      spa_pkg::ACT_REL_ID, spa_pkg::ACT_LOOKUP_ID: begin
        hit = live[cmp_i] && slot_rdata.ident == id_q && id_q != 32'd0;
      end
      spa_pkg::ACT_REL_LOC: begin
        hit = live[cmp_i] && slot_rdata.loc_index == li_q;
      end
      spa_pkg::ACT_COUNT: begin
        hit = live[cmp_i] && slot_rdata.loc_index == li_q && slot_rdata.loc_gen == lg_q;
      end
      spa_pkg::ACT_LOOKUP_NTH: begin
        hit = live[cmp_i];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    sel = hit && (act_q != spa_pkg::ACT_LOOKUP_NTH || 7'(scan_cnt) == {1'b0, pos_q});
  end

  always_comb begin
    state_next  = state;
    load        = 1'b0;
    res_status  = spa_pkg::ST_OK;
    res_has_rec = 1'b0;
    res_rec     = hit_rec;
    res_slot    = hit_slot;
    res_count   = act_cnt;
    res_last    = 1'b1;
    slot_we     = 1'b0;
    list_we     = 1'b0;
    list_waddr  = j[IW-1:0];
    list_wdata  = list_rdata;
    list_raddr  = j[IW-1:0];
    slot_raddr  = cur_s;
    case (state)
      spa_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.action inside {spa_pkg::ACT_CLEAR, spa_pkg::ACT_UNUSED}) begin
            state_next = spa_pkg::S_DECIDE;
          end else begin
            state_next = spa_pkg::S_SCAN;
          end
        end
      end
      spa_pkg::S_SCAN: begin
        slot_raddr = scan_i;
        if (cmp_v && cmp_i == IW'(NS - 1)) begin
          state_next = spa_pkg::S_DECIDE;
        end
      end
      spa_pkg::S_DECIDE: begin
        if (out_free) begin
          state_next = spa_pkg::S_IDLE;
          load       = 1'b1;
          case (act_q)
            spa_pkg::ACT_ALLOC: begin
              if (found) begin
                res_has_rec = 1'b1;
                res_rec     = slot_wdata;
                res_count   = act_cnt + CW'(1);
                slot_we     = 1'b1;
                list_we     = 1'b1;
                list_waddr  = act_cnt[IW-1:0];
                list_wdata  = hit_slot;
              end else begin
                res_status = spa_pkg::ST_FULL;
              end
            end
            spa_pkg::ACT_REL_ID: begin
              if (found) begin
                res_has_rec = 1'b1;
                res_count   = act_cnt - CW'(1);
                state_next  = spa_pkg::S_LF_RD;
              end else begin
                res_status = spa_pkg::ST_NOTFOUND;
              end
            end
            spa_pkg::ACT_REL_LOC: begin
              if (scan_cnt == '0) begin
                res_status = spa_pkg::ST_NOTFOUND;
              end else begin
                load       = 1'b0;
                state_next = spa_pkg::S_LR_RD;
              end
            end
            spa_pkg::ACT_COUNT: begin
              res_count = scan_cnt;
            end
            spa_pkg::ACT_LOOKUP_ID, spa_pkg::ACT_LOOKUP_NTH: begin
              res_has_rec = found;
              res_status  = found ? spa_pkg::ST_OK : spa_pkg::ST_NOTFOUND;
            end
            spa_pkg::ACT_CLEAR: begin
              res_count = '0;
            end
            default: begin
              res_status = spa_pkg::ST_NOTFOUND;
            end
          endcase
        end
      end
      spa_pkg::S_LF_RD: begin
        state_next = spa_pkg::S_LF_CMP;
      end
      spa_pkg::S_LF_CMP: begin
        if (list_rdata == hit_slot) begin
          state_next = spa_pkg::S_TAIL_RD;
        end else begin
          state_next = spa_pkg::S_LF_RD;
        end
      end
      spa_pkg::S_LR_RD: begin
        if (j >= act_cnt) begin
          state_next = spa_pkg::S_IDLE;
        end else begin
          state_next = spa_pkg::S_LR_SL;
        end
      end
      spa_pkg::S_LR_SL: begin
        slot_raddr = list_rdata;
        state_next = spa_pkg::S_LR_CMP;
      end
      spa_pkg::S_LR_CMP: begin
        if (slot_rdata.loc_index != li_q) begin
          state_next = spa_pkg::S_LR_RD;
        end else if (out_free) begin
          load        = 1'b1;
          res_has_rec = 1'b1;
          res_rec     = slot_rdata;
          res_slot    = cur_s;
          res_count   = final_cnt;
          res_last    = (emitted + CW'(1) == scan_cnt);
          state_next  = spa_pkg::S_TAIL_RD;
        end
      end
      spa_pkg::S_TAIL_RD: begin
        list_raddr = IW'(act_cnt - CW'(1));
        state_next = spa_pkg::S_TAIL_WR;
      end
      spa_pkg::S_TAIL_WR: begin
        list_we = 1'b1;
        if (act_q == spa_pkg::ACT_REL_LOC && emitted != scan_cnt) begin
          state_next = spa_pkg::S_LR_RD;
        end else begin
          state_next = spa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      act_cnt    <= '0;
      next_ident <= 32'd1;
      cmp_v      <= 1'b0;
    end else begin
      case (state)
        spa_pkg::S_IDLE: begin
          if (req.valid) begin
            act_q    <= req.action;
            id_q     <= req.cargo_id;
            type_q   <= req.res_type;
            amount_q <= req.amount;
            li_q     <= req.loc_index;
            lg_q     <= req.loc_generation;
            pos_q    <= req.position;
            scan_i   <= '0;
            iss_done <= 1'b0;
            cmp_v    <= 1'b0;
            scan_cnt <= '0;
            found    <= 1'b0;
          end
        end
        spa_pkg::S_SCAN: begin
          cmp_v <= !iss_done;
          cmp_i <= scan_i;
          if (!iss_done) begin
            if (scan_i == IW'(NS - 1)) begin
              iss_done <= 1'b1;
            end else begin
              scan_i <= scan_i + IW'(1);
            end
          end
          if (cmp_v) begin
            if (hit) begin
              scan_cnt <= scan_cnt + CW'(1);
            end
            if (sel && !found) begin
              found    <= 1'b1;
              hit_slot <= cmp_i;
              hit_rec  <= slot_rdata;
            end
          end
        end
        spa_pkg::S_DECIDE: begin
          cmp_v <= 1'b0;
          if (out_free) begin
            j       <= '0;
            emitted <= '0;
            case (act_q)
              spa_pkg::ACT_ALLOC: begin
                if (found) begin
                  live[hit_slot] <= 1'b1;
                  act_cnt        <= act_cnt + CW'(1);
                  next_ident     <= ident_inc;
                end
              end
              spa_pkg::ACT_REL_ID: begin
                if (found) begin
                  live[hit_slot] <= 1'b0;
                end
              end
              spa_pkg::ACT_REL_LOC: begin
                final_cnt <= act_cnt - scan_cnt;
              end
              spa_pkg::ACT_CLEAR: begin
                live    <= '0;
                act_cnt <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        spa_pkg::S_LF_CMP: begin
          if (list_rdata != hit_slot) begin
            j <= j + CW'(1);
          end
        end
        spa_pkg::S_LR_SL: begin
          cur_s <= list_rdata;
        end
        spa_pkg::S_LR_CMP: begin
          if (slot_rdata.loc_index != li_q) begin
            j <= j + CW'(1);
          end else if (out_free) begin
            live[cur_s] <= 1'b0;
            emitted     <= emitted + CW'(1);
          end
        end
        spa_pkg::S_TAIL_WR: begin
          act_cnt <= act_cnt - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_status <= res_status;
      o_rec    <= res_has_rec ? res_rec : '0;
      o_slot   <= res_has_rec ? res_slot : '0;
      o_count  <= res_count;
      o_last   <= res_last;
    end
  end

  assign req.ready = (state == spa_pkg::S_IDLE);

  assign rsp.valid              = o_valid;
  assign rsp.status             = o_status;
  assign rsp.out_id             = o_rec.ident;
  assign rsp.out_slot           = 6'(o_slot);
  assign rsp.out_type           = o_rec.kind;
  assign rsp.out_amount         = o_rec.qty;
  assign rsp.out_loc_index      = o_rec.loc_index;
  assign rsp.out_loc_generation = o_rec.loc_gen;
  assign rsp.out_count          = 7'(o_count);
  assign rsp.last               = o_last;

endmodule
